// ----- rtl/core/css_pkg.sv -----
`default_nettype none

package css_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned START_W    = 16;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LEN_REG_W  = 6;
  localparam int unsigned NEEDLE_WORDS = 4;

  // parameter defaults
  localparam int unsigned NEEDLE_MAX_DEF = 32;
  localparam int unsigned TEXT_MAX_DEF   = 65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN    = 3'd4;

  localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

  // map upper case letters onto lower case
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/css_text_if.sv -----
`default_nettype none

interface css_text_if;
  logic                      valid;
  logic                      ready;
  logic [css_pkg::BYTE_W-1:0] text_byte;
  logic                      text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/css_result_if.sv -----
`default_nettype none

interface css_result_if;
  logic                       valid;
  logic                       ready;
  logic                       match_found;
  logic [css_pkg::START_W-1:0] match_start;
  logic                       text_overflow;

  modport source (output valid, output match_found, output match_start,
                  output text_overflow, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input text_overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/caseless_substring_search_unit.sv -----
// the last text byte passes the input register, then loads the result register
// throughput: one text byte per cycle, set by the full-width parallel window compare,
// unless a stalled result holds a following last byte in the input register, which
// then blocks every byte behind it; bytes before that last byte keep flowing
// reset: rst_ni asynchronous active low; clears needle registers, window, position,
// match and overflow state, and the valid flags of both stages
`default_nettype none

module caseless_substring_search_unit #(
  parameter int unsigned NEEDLE_MAX = css_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned TEXT_MAX   = css_pkg::TEXT_MAX_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [css_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [css_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  css_text_if.sink                               text_i,
  css_result_if.source                           result_o
);
  import css_pkg::*;

  localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned POS_W = $clog2(TEXT_MAX + 1);
  localparam int unsigned VEC_W = NEEDLE_MAX * BYTE_W;

  // needle configuration
  logic [CFG_DATA_W-1:0] needle_q [NEEDLE_WORDS];
  logic [LEN_REG_W-1:0]  needle_len_q;
  logic [NEEDLE_WORDS*CFG_DATA_W-1:0] needle_all;
  logic [LEN_W-1:0]      len_act;

  // input register
  logic              s1_valid_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_last_q;
  logic              s1_adv;
  logic              in_xfer;

  // per-text state
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               found_q, found_d;
  logic [START_W-1:0] start_q, start_d;
  logic               ovf_q, ovf_d;
  logic               in_range;
  logic               enough;
  logic [POS_W:0]     start_calc;
  logic               hit_raw;
  logic               hit_ok;
  logic [VEC_W-1:0]   window;

  // result register
  logic               res_valid_q;
  logic               res_found_q;
  logic [START_W-1:0] res_start_q;
  logic               res_ovf_q;

  // ---------------------------------------------------------------------------
  // configuration writes; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NEEDLE_WORDS; w++) begin
        needle_q[w] <= '0;
      end
      needle_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEEDLE_LOW:    needle_q[0]  <= cfg_data_i;
        CFG_NEEDLE_SECOND: needle_q[1]  <= cfg_data_i;
        CFG_NEEDLE_THIRD:  needle_q[2]  <= cfg_data_i;
        CFG_NEEDLE_HIGH:   needle_q[3]  <= cfg_data_i;
        CFG_NEEDLE_LEN:    needle_len_q <= cfg_data_i[LEN_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign needle_all = {needle_q[3], needle_q[2], needle_q[1], needle_q[0]};

  // lengths above the window size clamp to the window size
  assign len_act = (needle_len_q > LEN_REG_W'(NEEDLE_MAX)) ?
                   LEN_W'(NEEDLE_MAX) : needle_len_q[LEN_W-1:0];

  // ---------------------------------------------------------------------------
  // handshake: a byte without last always moves on; a last byte needs the
  // result register free or draining this cycle
  // ---------------------------------------------------------------------------
  assign s1_adv       = s1_valid_q && (!s1_last_q || !res_valid_q || result_o.ready);
  assign text_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer      = text_i.valid && text_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= text_i.text_byte;
      s1_last_q <= text_i.text_last;
    end
  end

  // ---------------------------------------------------------------------------
  // sliding window: newest byte at index 0, held bytes behind it
  // ---------------------------------------------------------------------------
  generate
    if (NEEDLE_MAX > 1) begin : g_win
      logic [(NEEDLE_MAX-1)*BYTE_W-1:0] win_q;

      assign window = {win_q, s1_byte_q};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          win_q <= '0;
        end else if (s1_adv) begin
          if (s1_last_q) begin
            win_q <= '0;
          end else if (in_range) begin
            win_q <= window[(NEEDLE_MAX-1)*BYTE_W-1:0];
          end
        end
      end
    end else begin : g_no_win
      assign window = s1_byte_q;
    end
  endgenerate

  css_window_match #(
    .NEEDLE_MAX(NEEDLE_MAX)
  ) u_match (
    .window_i (window),
    .needle_i (needle_all[VEC_W-1:0]),
    .len_i    (len_act),
    .hit_o    (hit_raw)
  );

  // ---------------------------------------------------------------------------
  // match bookkeeping; only the first match of a text is kept
  // ---------------------------------------------------------------------------
  assign in_range   = pos_q < POS_W'(TEXT_MAX);
  assign enough     = ({1'b0, pos_q} + 1'b1) >= (POS_W+1)'(len_act);
  assign start_calc = {1'b0, pos_q} + 1'b1 - (POS_W+1)'(len_act);
  assign hit_ok     = in_range && !found_q && (len_act != '0) && enough && hit_raw;

  always_comb begin
    found_d = found_q | hit_ok;
    start_d = hit_ok ? START_W'(start_calc) : start_q;
    ovf_d   = ovf_q | !in_range;
    pos_d   = in_range ? pos_q + 1'b1 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      found_q <= 1'b0;
      start_q <= '0;
      ovf_q   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        pos_q   <= '0;
        found_q <= 1'b0;
        start_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        found_q <= found_d;
        start_q <= start_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register; an empty needle always matches at zero
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      res_found_q <= (len_act == '0) ? 1'b1 : found_d;
      res_start_q <= ((len_act == '0) || !found_d) ? '0 : start_d;
      res_ovf_q   <= ovf_d;
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.match_found   = res_found_q;
  assign result_o.match_start   = res_start_q;
  assign result_o.text_overflow = res_ovf_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a last byte");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(TEXT_MAX))
    else $error("byte position beyond limit");

  a_found_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (pos_q != '0))
    else $error("match recorded with no bytes");

  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !result_o.ready && s1_valid_q && s1_last_q) |-> !s1_adv)
    else $error("last byte overran a pending result");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (pos_q == '0 && !found_q && !ovf_q))
    else $error("text state not cleared after last byte");

endmodule

`default_nettype wire

// ----- rtl/core/css_window_match.sv -----
`default_nettype none

module css_window_match #(
  parameter int unsigned NEEDLE_MAX = css_pkg::NEEDLE_MAX_DEF
) (
  input  wire logic [NEEDLE_MAX*css_pkg::BYTE_W-1:0]   window_i,
  input  wire logic [NEEDLE_MAX*css_pkg::BYTE_W-1:0]   needle_i,
  input  wire logic [$clog2(NEEDLE_MAX+1)-1:0]         len_i,
  output logic                                         hit_o
);
  import css_pkg::*;

  localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned VEC_W = NEEDLE_MAX * BYTE_W;
  localparam int unsigned SH_W  = LEN_W + 3;

  logic [VEC_W-1:0]      needle_rev;
  logic [VEC_W-1:0]      needle_al;
  logic [LEN_W-1:0]      shift_bytes;
  logic [SH_W-1:0]       shift_bits;
  logic [NEEDLE_MAX-1:0] byte_eq;

  // window byte 0 is the newest; it meets the last needle byte
  always_comb begin
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      needle_rev[k*BYTE_W +: BYTE_W] =
        fold_case(needle_i[(NEEDLE_MAX-1-k)*BYTE_W +: BYTE_W]);
    end
  end

  assign shift_bytes = LEN_W'(NEEDLE_MAX) - len_i;
  assign shift_bits  = {shift_bytes, 3'b000};
  assign needle_al   = needle_rev >> shift_bits;

  always_comb begin
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      byte_eq[k] = (fold_case(window_i[k*BYTE_W +: BYTE_W]) ==
                    needle_al[k*BYTE_W +: BYTE_W]) || (LEN_W'(k) >= len_i);
    end
  end

  assign hit_o = &byte_eq;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
  import css_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int QUIET_LIMIT   = 1000;  // cycles without any transfer before giving up
  localparam int RANDOM_BYTES  = 1300;
  localparam int SETTLE_CYCLES = 4;     // wait after the last expected result has arrived
  localparam int IDLE_PCT      = 7;
  localparam int TEXT_LIMIT    = TEXT_MAX_DEF;
  localparam int NEEDLE_LIMIT  = NEEDLE_MAX_DEF;

  // bytes next to the letter ranges, one case bit away from each other
  localparam logic [BYTE_W-1:0] AT_SIGN   = 8'h40;
  localparam logic [BYTE_W-1:0] L_BRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] BACKTICK  = 8'h60;
  localparam logic [BYTE_W-1:0] L_BRACE   = 8'h7B;
  localparam logic [BYTE_W-1:0] LOWER_A   = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z   = 8'h7A;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
    logic               overflow;
  } search_result_t;

  // letters compare without case, everything else compares as is
  function automatic logic [BYTE_W-1:0] ascii_lower(input logic [BYTE_W-1:0] b);
    return (b >= UPPER_A && b <= UPPER_Z) ? (b | CASE_DELTA) : b;
  endfunction

  // predicts the search outcome of each text and checks the results in order
  class search_scoreboard;
    logic [CFG_DATA_W-1:0] needle_word [NEEDLE_WORDS];
    logic [LEN_REG_W-1:0]  needle_len;
    logic [BYTE_W-1:0]     window [NEEDLE_LIMIT];  // entry 0 is the newest byte
    logic [16:0]           position;
    logic                  found;
    logic [START_W-1:0]    found_at;
    logic                  dropped;
    search_result_t        outcome_q [$];
    int                    errors;

    function new();
      foreach (needle_word[k]) needle_word[k] = '0;
      needle_len = '0;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[k]) window[k] = '0;
      position = '0;
      found    = 1'b0;
      found_at = '0;
      dropped  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NEEDLE_LOW:    needle_word[0] = data;
        CFG_NEEDLE_SECOND: needle_word[1] = data;
        CFG_NEEDLE_THIRD:  needle_word[2] = data;
        CFG_NEEDLE_HIGH:   needle_word[3] = data;
        CFG_NEEDLE_LEN:    needle_len = data[LEN_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function int active_len();
      return (needle_len > NEEDLE_LIMIT) ? NEEDLE_LIMIT : int'(needle_len);
    endfunction

    function logic [BYTE_W-1:0] needle_at(int k);
      return needle_word[k / 8][8 * (k % 8) +: 8];
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void note_text(logic [BYTE_W-1:0] b, logic last);
      int             n;
      int             k;
      logic           hit;
      search_result_t r;
      n = active_len();
      if (position < TEXT_LIMIT) begin
        if (!found && n != 0 && position + 1 >= n) begin
          hit = (ascii_lower(b) == ascii_lower(needle_at(n - 1)));
          for (k = 0; k + 1 < n; k++) begin
            if (ascii_lower(window[n - 2 - k]) != ascii_lower(needle_at(k))) hit = 1'b0;
          end
          if (hit) begin
            found    = 1'b1;
            found_at = START_W'(position + 1 - n);
          end
        end
        for (k = NEEDLE_LIMIT - 1; k > 0; k--) window[k] = window[k - 1];
        window[0] = b;
        position++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        r.found    = (n == 0) ? 1'b1 : found;
        r.start    = (n == 0 || !found) ? '0 : found_at;
        r.overflow = dropped;
        outcome_q.push_back(r);
        clear_text();
      end
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic f, logic [START_W-1:0] s, logic o);
      search_result_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("result with nothing expected: found=%0b start=%0d", f, s));
        return;
      end
      want = outcome_q.pop_front();
      if (f !== want.found)
        report($sformatf("match_found %0b, expected %0b", f, want.found));
      if (s !== want.start)
        report($sformatf("match_start %0d, expected %0d", s, want.start));
      if (o !== want.overflow)
        report($sformatf("text_overflow %0b, expected %0b", o, want.overflow));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  calm;        // no idling on either side while set
  logic [CFG_DATA_W-1:0] needle_w [NEEDLE_WORDS];
  int                    bytes_sent;
  search_scoreboard      sb;

  css_text_if   text_if ();
  css_result_if result_if ();

  caseless_substring_search_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .text_i     (text_if),
    .result_o   (result_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // result side: check every transfer, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      sb.check_result(result_if.match_found, result_if.match_start, result_if.text_overflow);
    end
    result_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // give up when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("** caseless_substring_search_unit: FAILED **");
    $finish;
  end

  // one byte transfer, with random idle cycles in front of it
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        text_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    text_if.text_last <= last;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    sb.note_text(b, last);
  endtask

  task automatic send_str(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
  endtask

  // up to eight bytes, lowest byte first, last mark on the final one
  task automatic send_packed(input logic [63:0] data, input int n);
    for (int k = 0; k < n; k++) send_byte(data[8 * k +: 8], k == n - 1);
  endtask

  // hold the text side until every expected result is in and the pipe is empty
  task automatic settle();
    text_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write enable stays up across back to back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_needle(input int len);
    settle();
    write_reg(CFG_NEEDLE_LOW, needle_w[0]);
    write_reg(CFG_NEEDLE_SECOND, needle_w[1]);
    write_reg(CFG_NEEDLE_THIRD, needle_w[2]);
    write_reg(CFG_NEEDLE_HIGH, needle_w[3]);
    write_reg(CFG_NEEDLE_LEN, CFG_DATA_W'(len));
    cfg_we_i <= 1'b0;
  endtask

  // needle from a string, random junk in the unused bytes
  function automatic void load_string(input string s);
    for (int k = 0; k < NEEDLE_LIMIT; k++) begin
      needle_w[k / 8][8 * (k % 8) +: 8] = (k < s.len()) ? s[k] : 8'($urandom_range(255));
    end
  endfunction

  function automatic logic [BYTE_W-1:0] any_case(input logic [BYTE_W-1:0] b);
    if ((b | CASE_DELTA) >= LOWER_A && (b | CASE_DELTA) <= LOWER_Z) begin
      return $urandom_range(1) ? (b | CASE_DELTA) : (b & ~CASE_DELTA);
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] random_letter();
    return any_case(LOWER_A + 8'($urandom_range(25)));
  endfunction

  function automatic logic [BYTE_W-1:0] boundary_byte();
    case ($urandom_range(7))
      0: return AT_SIGN;
      1: return L_BRACKET;
      2: return BACKTICK;
      3: return L_BRACE;
      4: return UPPER_A;
      5: return UPPER_Z;
      6: return LOWER_A;
      default: return LOWER_Z;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] needle_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return random_letter();
    if (r < 75) return boundary_byte();
    if (r < 85) return 8'hC0 + 8'($urandom_range(63));  // letters shifted up, not folded
    return 8'($urandom_range(255));
  endfunction

  // background text: letters, needle bytes and near misses
  function automatic logic [BYTE_W-1:0] filler_byte();
    logic [BYTE_W-1:0] b;
    int                r;
    r = $urandom_range(99);
    if (r < 35) b = random_letter();
    else if (r < 60 && sb.active_len() > 0)
      b = any_case(sb.needle_at($urandom_range(sb.active_len() - 1)));
    else if (r < 75) b = boundary_byte();
    else b = 8'($urandom_range(1, 255));
    return (b == 8'h00) ? 8'h01 : b;
  endfunction

  // needle byte in random case, now and then broken by a single bit flip
  function automatic logic [BYTE_W-1:0] planted_byte(input int k);
    logic [BYTE_W-1:0] b;
    b = sb.needle_at(k);
    if ($urandom_range(99) < 4) b = b ^ (8'h01 << $urandom_range(7));
    b = any_case(b);
    return (b == 8'h00) ? 8'h01 : b;
  endfunction

  // at1 and at2 place copies of the needle, negative means none
  task automatic send_text(input int n, input int at1, input int at2);
    int                len;
    logic [BYTE_W-1:0] b;
    len = sb.active_len();
    for (int k = 0; k < n; k++) begin
      if (at1 >= 0 && k >= at1 && k < at1 + len) b = planted_byte(k - at1);
      else if (at2 >= 0 && k >= at2 && k < at2 + len) b = planted_byte(k - at2);
      else b = filler_byte();
      send_byte(b, k == n - 1);
    end
  endtask

  task automatic random_needle();
    int len;
    int r;
    r = $urandom_range(99);
    if (r < 5) len = 0;
    else if (r < 10) len = $urandom_range(33, 63);  // clamps to the maximum
    else if (r < 16) len = NEEDLE_LIMIT;
    else if (r < 60) len = $urandom_range(1, 4);
    else len = $urandom_range(5, NEEDLE_LIMIT - 1);
    for (int k = 0; k < NEEDLE_LIMIT; k++) needle_w[k / 8][8 * (k % 8) +: 8] = needle_char();
    r = $urandom_range(99);
    if (r < 4) foreach (needle_w[w]) needle_w[w] = '1;
    else if (r < 7) foreach (needle_w[w]) needle_w[w] = '0;
    apply_needle(len);
  endtask

  task automatic random_text();
    int len;
    int n;
    int at1;
    int at2;
    len = sb.active_len();
    n   = ($urandom_range(99) < 10) ? $urandom_range(41, 300) : $urandom_range(1, 40);
    at1 = -1;
    at2 = -1;
    if (len > 0 && n >= len) begin
      if ($urandom_range(99) < 70) at1 = $urandom_range(n - len);
      if ($urandom_range(99) < 30) at2 = $urandom_range(n - len);
    end
    send_text(n, at1, at2);
    bytes_sent += n;
  endtask

  initial begin
    int texts_left;
    sb                  = new();
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.text_last   = 1'b0;
    result_if.ready     = 1'b0;
    calm                = 1'b0;
    bytes_sent          = 0;
    texts_left          = 0;
    foreach (needle_w[w]) needle_w[w] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty needle straight out of reset matches at the start
    send_str("x");

    // mixed case hit, then a text shorter than the needle
    load_string("aBc");
    apply_needle(3);
    send_str("xAbC");
    send_str("ab");

    // neighbors of the letter ranges must not fold, earliest hit at 4
    load_string("");
    needle_w[0][31:0] = {L_BRACE, BACKTICK, L_BRACKET, AT_SIGN};
    apply_needle(4);
    send_packed({L_BRACE, BACKTICK, L_BRACKET, AT_SIGN,
                 L_BRACKET, AT_SIGN, L_BRACE, BACKTICK}, 8);

    // oversized length is taken as the maximum
    foreach (needle_w[w]) needle_w[w] = '1;
    apply_needle(63);
    send_packed(64'hFF_FF_FF, 3);

    // zero byte in the needle only matches zero
    load_string("a");
    needle_w[0][15:8] = 8'h00;
    apply_needle(2);
    send_str("aa");

    // needle swapped in the middle of a text, window compared to the new one
    load_string("zz");
    apply_needle(2);
    send_byte("x", 1'b0);
    send_byte("a", 1'b0);
    load_string("aB");
    apply_needle(2);
    send_byte("b", 1'b1);

    // ends of both letter ranges
    load_string("Az");
    apply_needle(2);
    send_str("aZ");

    // random needles and texts, with a stretch of back to back traffic
    while (bytes_sent < RANDOM_BYTES) begin
      if (texts_left == 0) begin
        random_needle();
        texts_left = $urandom_range(1, 6);
      end
      calm <= (bytes_sent >= 500 && bytes_sent < 800);
      if ($urandom_range(99) < 8) settle();
      random_text();
      texts_left--;
    end

    settle();
    if (sb.errors == 0) begin
      $display("** caseless_substring_search_unit: PASSED **");
    end else begin
      $display("** caseless_substring_search_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
